@@ hw/rtl/mme_pkg.sv @@
// ============================================================================
// mme_pkg: shared types and constants of the matrix multiply engine
// Command codes passed through the command queue, result status codes,
// configuration register indexes and the dimension clamp.
// ============================================================================
package mme_pkg;

    localparam int CFG_W       = 4;   // width of one dimension register
    localparam int CFG_IDX_W   = 4;   // width of the register index on the config port
    localparam int OUT_IDX_W   = 3;   // row_index / col_index width
    localparam int PROD_W      = 35;  // product_value width
    localparam int STATUS_W    = 2;
    localparam int OUT_TDATA_W = 48;  // row + col + product, padded to bytes

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 4'd3;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ORDER    = 2'd2;

    typedef enum logic [2:0] {
        CMD_STORE_A,
        CMD_STORE_B,
        CMD_STORE_B_RUN,   // last element of B: store it, then compute C
        CMD_MISMATCH,
        CMD_ORDER
    } cmd_kind_t;

    localparam int CMD_KIND_W = $bits(cmd_kind_t);

    // Clamped matrix sizes, 1..MAX_DIM
    typedef struct packed {
        logic [CFG_W-1:0] ra;
        logic [CFG_W-1:0] ca;
        logic [CFG_W-1:0] rb;
        logic [CFG_W-1:0] cb;
    } dims_t;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] max_dim);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = CFG_W'(1);
        else if (v > max_dim)
            r = max_dim;
        else
            r = v;
        return r;
    endfunction

endpackage

@@ hw/rtl/matrix_multiply_engine.sv @@
// ============================================================================
// matrix_multiply_engine: integer matrix multiply C = A * B
// Flow: a load item passes the front combinationally, is registered in the queue
//   and is written to its store when the back end pops it; a status result is
//   registered into the output register when popped, once that register is free.
// Throughput: loads sustain one transfer per cycle while the queue has room (the
//   back end pops only when idle). After the last B element, ra * cb C elements
//   each take one store read per multiply-add plus the read and product stages.
// Reset: dimension registers to 8, loading restarts at A; stores stay
//   unwritten and need no clearing pass.
// ============================================================================
module matrix_multiply_engine #(
    parameter int MAX_DIM     = 8,    // largest matrix dimension, 2..8
    parameter int ELEM_WIDTH  = 16,   // element width, 8..32
    parameter int QUEUE_DEPTH = 4     // commands held between front and back
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mme_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]             cfg_data,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((ELEM_WIDTH+7)/8)*8-1:0]       s_axis_tdata,  // element
    input  logic [0:0]                            s_axis_tuser,  // func
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [mme_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // row_index, col_index,
                                                                 // product_value, zero pad
    output logic [mme_pkg::STATUS_W-1:0]          m_axis_tuser,  // status
    output logic                                  m_axis_tlast
);

    import mme_pkg::*;

    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int Q_W    = CMD_KIND_W + ADDR_W + ELEM_WIDTH;
    localparam int PAD_W  = OUT_TDATA_W - 2 * OUT_IDX_W - PROD_W;

    // front -> queue
    logic                  f_cmd_valid;
    logic                  f_cmd_ready;
    cmd_kind_t             f_cmd_kind;
    logic [ADDR_W-1:0]     f_cmd_addr;
    logic [ELEM_WIDTH-1:0] f_cmd_elem;
    dims_t                 dims;

    // queue -> back
    logic                  b_cmd_valid;
    logic                  b_cmd_ready;
    logic [Q_W-1:0]        b_cmd_data;
    cmd_kind_t             b_cmd_kind;

    logic [OUT_IDX_W-1:0]  out_row;
    logic [OUT_IDX_W-1:0]  out_col;
    logic [PROD_W-1:0]     out_value;

    // Front: dimension registers, load position, classification of each item
    mme_front #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_func    (s_axis_tuser[0]),
        .in_element (s_axis_tdata[ELEM_WIDTH-1:0]),
        .cmd_valid  (f_cmd_valid),
        .cmd_ready  (f_cmd_ready),
        .cmd_kind   (f_cmd_kind),
        .cmd_addr   (f_cmd_addr),
        .cmd_elem   (f_cmd_elem),
        .dims       (dims)
    );

    // Queue decouples item intake from the compute sequencer
    mme_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_cmd_valid),
        .push_ready (f_cmd_ready),
        .push_data  ({f_cmd_kind, f_cmd_addr, f_cmd_elem}),
        .pop_valid  (b_cmd_valid),
        .pop_ready  (b_cmd_ready),
        .pop_data   (b_cmd_data)
    );

    assign b_cmd_kind = cmd_kind_t'(b_cmd_data[Q_W-1 -: CMD_KIND_W]);

    // Back: stores, multiply-accumulate sequencer, output register
    mme_back #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .dims       (dims),
        .cmd_valid  (b_cmd_valid),
        .cmd_ready  (b_cmd_ready),
        .cmd_kind   (b_cmd_kind),
        .cmd_addr   (b_cmd_data[ELEM_WIDTH +: ADDR_W]),
        .cmd_elem   (b_cmd_data[ELEM_WIDTH-1:0]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_value  (out_value),
        .out_status (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, out_value, out_col, out_row};

endmodule

@@ hw/rtl/mme_ram.sv @@
// ============================================================================
// mme_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ============================================================================
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/mme_queue.sv @@
// ============================================================================
// mme_queue: short command queue between front and back
// Register-based FIFO, valid/ready on both sides.
// ============================================================================
module mme_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = data_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ hw/rtl/mme_front.sv @@
// ============================================================================
// mme_front: configuration registers and input classification
// Holds the dimension registers and load position, turns each accepted
// input item into one command for the back end.
// ============================================================================
module mme_front #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // configuration writes
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [mme_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]                cfg_data,
    // input items
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic                                     in_func,
    input  logic [ELEM_WIDTH-1:0]                    in_element,
    // command out
    output logic                                     cmd_valid,
    input  logic                                     cmd_ready,
    output mme_pkg::cmd_kind_t                       cmd_kind,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       cmd_addr,
    output logic [ELEM_WIDTH-1:0]                    cmd_elem,
    output mme_pkg::dims_t                           dims
);

    import mme_pkg::*;

    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int CNT_W  = $clog2(MAX_DIM * MAX_DIM + 1);

    logic [CFG_W-1:0] rows_a_reg;
    logic [CFG_W-1:0] cols_a_reg;
    logic [CFG_W-1:0] rows_b_reg;
    logic [CFG_W-1:0] cols_b_reg;
    logic [CNT_W-1:0] load_count_reg;
    logic             loading_b_reg;

    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] size_a;
    logic [CNT_W-1:0] size_b;
    logic             accept;
    logic             cfg_hit;

    assign dims.ra = clamp_dim(rows_a_reg, CFG_W'(MAX_DIM));
    assign dims.ca = clamp_dim(cols_a_reg, CFG_W'(MAX_DIM));
    assign dims.rb = clamp_dim(rows_b_reg, CFG_W'(MAX_DIM));
    assign dims.cb = clamp_dim(cols_b_reg, CFG_W'(MAX_DIM));

    assign size_a    = CNT_W'(dims.ra) * CNT_W'(dims.ca);
    assign size_b    = CNT_W'(dims.rb) * CNT_W'(dims.cb);
    assign count_inc = load_count_reg + CNT_W'(1);

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index == REG_ROWS_A || cfg_index == REG_COLS_A ||
                                     cfg_index == REG_ROWS_B || cfg_index == REG_COLS_B);

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign accept    = in_valid && cmd_ready;
    assign cmd_addr  = load_count_reg[ADDR_W-1:0];
    assign cmd_elem  = in_element;

    always_comb
    begin
        if (dims.ca != dims.rb)
            cmd_kind = CMD_MISMATCH;
        else if (in_func != loading_b_reg)
            cmd_kind = CMD_ORDER;
        else if (!loading_b_reg)
            cmd_kind = CMD_STORE_A;
        else if (count_inc == size_b)
            cmd_kind = CMD_STORE_B_RUN;
        else
            cmd_kind = CMD_STORE_B;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg     <= CFG_W'(8);
            cols_a_reg     <= CFG_W'(8);
            rows_b_reg     <= CFG_W'(8);
            cols_b_reg     <= CFG_W'(8);
            load_count_reg <= '0;
            loading_b_reg  <= 1'b0;
        end
        else if (cfg_hit)
        begin
            case (cfg_index)
                REG_ROWS_A: rows_a_reg <= cfg_data;
                REG_COLS_A: cols_a_reg <= cfg_data;
                REG_ROWS_B: rows_b_reg <= cfg_data;
                REG_COLS_B: cols_b_reg <= cfg_data;
                default:    ;
            endcase
            load_count_reg <= '0;
            loading_b_reg  <= 1'b0;
        end
        else if (accept)
        begin
            case (cmd_kind)
                CMD_STORE_A:
                begin
                    if (count_inc == size_a)
                    begin
                        load_count_reg <= '0;
                        loading_b_reg  <= 1'b1;
                    end
                    else
                    begin
                        load_count_reg <= count_inc;
                    end
                end
                CMD_STORE_B:
                begin
                    load_count_reg <= count_inc;
                end
                CMD_STORE_B_RUN:
                begin
                    load_count_reg <= '0;
                    loading_b_reg  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

endmodule

@@ hw/rtl/mme_back.sv @@
// ============================================================================
// mme_back: element stores and dot-product sequencer
// Executes queued commands: writes the A/B stores, emits status results and
// walks all dot products through one multiply-accumulate pipe.
// ============================================================================
module mme_back #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mme_pkg::dims_t                       dims,
    // command in
    input  logic                                 cmd_valid,
    output logic                                 cmd_ready,
    input  mme_pkg::cmd_kind_t                   cmd_kind,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   cmd_addr,
    input  logic [ELEM_WIDTH-1:0]                cmd_elem,
    // result out
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [mme_pkg::OUT_IDX_W-1:0]        out_row,
    output logic [mme_pkg::OUT_IDX_W-1:0]        out_col,
    output logic [mme_pkg::PROD_W-1:0]           out_value,
    output logic [mme_pkg::STATUS_W-1:0]         out_status,
    output logic                                 out_last
);

    import mme_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int MUL_W  = 2 * ELEM_WIDTH;
    localparam int EXT_W  = (MUL_W > PROD_W) ? MUL_W : PROD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [ADDR_W-1:0] row_base_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [ADDR_W-1:0] b_addr_reg;

    logic                  out_valid_reg;
    logic [OUT_IDX_W-1:0]  out_row_reg;
    logic [OUT_IDX_W-1:0]  out_col_reg;
    logic [PROD_W-1:0]     out_value_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic                  out_last_reg;

    logic                     rd_v_reg;
    logic                     mul_v_reg;
    logic signed [MUL_W-1:0]  mul_reg;
    logic signed [EXT_W-1:0]  mul_ext;
    logic [PROD_W-1:0]        acc_reg;

    logic [ELEM_WIDTH-1:0] a_rdata;
    logic [ELEM_WIDTH-1:0] b_rdata;
    logic                  out_free;
    logic                  is_status;
    logic                  pop;
    logic                  we_a;
    logic                  we_b;
    logic                  rd_en;
    logic                  last_i;
    logic                  last_j;
    logic                  last_k;
    logic                  emit;

    assign out_free  = !out_valid_reg || out_ready;
    assign is_status = cmd_kind inside {CMD_MISMATCH, CMD_ORDER};
    assign cmd_ready = (state_reg == S_IDLE) && (!is_status || out_free);
    assign pop       = cmd_valid && cmd_ready;
    assign we_a      = pop && (cmd_kind == CMD_STORE_A);
    assign we_b      = pop && (cmd_kind == CMD_STORE_B || cmd_kind == CMD_STORE_B_RUN);
    assign rd_en     = (state_reg == S_MAC);

    assign last_i = (CFG_W'(i_reg) == dims.ra - CFG_W'(1));
    assign last_j = (CFG_W'(j_reg) == dims.cb - CFG_W'(1));
    assign last_k = (CFG_W'(k_reg) == dims.ca - CFG_W'(1));
    assign emit   = (state_reg == S_DRAIN) && !rd_v_reg && !mul_v_reg && out_free;

    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (cmd_addr),
        .wdata (cmd_elem),
        .re    (rd_en),
        .raddr (a_addr_reg),
        .rdata (a_rdata)
    );

    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (cmd_addr),
        .wdata (cmd_elem),
        .re    (rd_en),
        .raddr (b_addr_reg),
        .rdata (b_rdata)
    );

    // multiply-accumulate pipe: read -> product register -> accumulator
    assign mul_ext = EXT_W'(mul_reg);

    always_ff @(posedge clk)
    begin
        mul_reg <= MUL_W'($signed(a_rdata)) * MUL_W'($signed(b_rdata));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            rd_v_reg  <= rd_en;
            mul_v_reg <= rd_v_reg;
            if (state_reg == S_IDLE || emit)
                acc_reg <= '0;
            else if (mul_v_reg)
                acc_reg <= acc_reg + mul_ext[PROD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            row_base_reg   <= '0;
            a_addr_reg     <= '0;
            b_addr_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_value_reg  <= '0;
            out_status_reg <= STAT_OK;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        case (cmd_kind)
                            CMD_STORE_B_RUN:
                            begin
                                i_reg        <= '0;
                                j_reg        <= '0;
                                k_reg        <= '0;
                                row_base_reg <= '0;
                                a_addr_reg   <= '0;
                                b_addr_reg   <= '0;
                                state_reg    <= S_MAC;
                            end
                            CMD_MISMATCH, CMD_ORDER:
                            begin
                                out_valid_reg  <= 1'b1;
                                out_row_reg    <= '0;
                                out_col_reg    <= '0;
                                out_value_reg  <= '0;
                                out_status_reg <= (cmd_kind == CMD_MISMATCH) ?
                                                  STAT_MISMATCH : STAT_ORDER;
                                out_last_reg   <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MAC:
                begin
                    a_addr_reg <= a_addr_reg + ADDR_W'(1);
                    b_addr_reg <= b_addr_reg + ADDR_W'(dims.cb);
                    k_reg      <= k_reg + IDX_W'(1);
                    if (last_k)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (emit)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_row_reg    <= OUT_IDX_W'(i_reg);
                        out_col_reg    <= OUT_IDX_W'(j_reg);
                        out_value_reg  <= acc_reg;
                        out_status_reg <= STAT_OK;
                        out_last_reg   <= last_i && last_j;
                        k_reg          <= '0;
                        if (last_j)
                        begin
                            j_reg      <= '0;
                            b_addr_reg <= '0;
                            if (last_i)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                i_reg        <= i_reg + IDX_W'(1);
                                row_base_reg <= row_base_reg + ADDR_W'(dims.ca);
                                a_addr_reg   <= row_base_reg + ADDR_W'(dims.ca);
                                state_reg    <= S_MAC;
                            end
                        end
                        else
                        begin
                            j_reg      <= j_reg + IDX_W'(1);
                            a_addr_reg <= row_base_reg;
                            b_addr_reg <= ADDR_W'(j_reg) + ADDR_W'(1);
                            state_reg  <= S_MAC;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule
